>>> src/rtpsgm_pkg.sv
`default_nettype none

package rtpsgm_pkg;

  localparam int HIST_BINS = 512;
  localparam int BIN_W     = $clog2(HIST_BINS);

  localparam logic [7:0] VERSION_OK = 8'h80;
  localparam logic [7:0] COMFORT_PT = 8'h0d;
  localparam int         MARKER_BIT = 7;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 136;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // Packed so that bad_version lands in bit 0.
  typedef struct packed {
    logic [31:0] total_gap;
    logic [8:0]  max_gap;
    logic [31:0] bin_count;
    logic [8:0]  bin;
    logic [31:0] timestamp_offset;
    logic        bad_timestamp;
    logic [15:0] seq_offset;
    logic        out_of_sequence;
    logic        negative_gap;
    logic        bad_version;
  } result_t;

endpackage

`default_nettype wire

>>> src/rtp_sequence_gap_monitor.sv
`default_nettype none

// RTP receive monitor. Each transfer is either a packet check (tuser = 0) or a
// histogram bin read (tuser = 1) and yields exactly one result transfer. The
// gap histogram lives in a single-port-write memory with a registered read; a
// packet reads its bin on acceptance and writes the incremented count in the
// following cycle, with forwarding to a transfer that directly follows a packet
// hitting the same bin. Throughput is one transfer per cycle while the result
// queue has room; results pass through the stage 1 registers and the result
// queue. After reset the block sweeps all HIST_BINS (512) bins to zero, one bin
// per cycle; s_axis_tready_o stays low during that sweep.
module rtp_sequence_gap_monitor
  import rtpsgm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  // [7:0] version_byte, [15:8] payload_byte, [31:16] seq_number,
  // [63:32] media_timestamp, [79:64] payload_length, [95:80] gap_ms,
  // [104:96] read_bin, rest zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] op
  input  wire logic                  s_axis_tuser_i,
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [0] bad_version, [1] negative_gap, [2] out_of_sequence, [18:3] seq_offset,
  // [19] bad_timestamp, [51:20] timestamp_offset, [60:52] bin,
  // [92:61] bin_count, [101:93] max_gap, [133:102] total_gap, rest zero
  output      logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // input unpack
  logic [7:0]  in_ver;
  logic [7:0]  in_pay;
  logic [15:0] in_seq;
  logic [31:0] in_ts;
  logic [15:0] in_len;
  logic [15:0] in_gap;
  logic [8:0]  in_rbin;
  op_e         in_op;

  assign in_ver  = s_axis_tdata_i[7:0];
  assign in_pay  = s_axis_tdata_i[15:8];
  assign in_seq  = s_axis_tdata_i[31:16];
  assign in_ts   = s_axis_tdata_i[63:32];
  assign in_len  = s_axis_tdata_i[79:64];
  assign in_gap  = s_axis_tdata_i[95:80];
  assign in_rbin = s_axis_tdata_i[104:96];
  assign in_op   = op_e'(s_axis_tuser_i);

  // histogram memory
  logic [31:0]      hist_mem [HIST_BINS];
  logic [31:0]      rd_data_q;
  logic             mem_we;
  logic [BIN_W-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic [BIN_W-1:0] mem_raddr;

  // clear sweep
  logic             clr_q;
  logic [BIN_W-1:0] clr_idx_q;

  // stage 1
  logic             s1_v_q;
  op_e              s1_op_q;
  logic [BIN_W-1:0] s1_addr_q;
  logic [8:0]       s1_bin_q;
  logic             s1_inrange_q;
  logic             s1_badver_q;
  logic             s1_neg_q;
  logic             s1_marker_q;
  logic [15:0]      s1_seq_q;
  logic [31:0]      s1_ts_q;
  logic [15:0]      s1_len_q;
  logic             fwd_hit_q;
  logic [31:0]      fwd_data_q;

  // scalar state
  logic [15:0] exp_seq_q;
  logic [31:0] exp_ts_q;
  logic        seen_q;
  logic [8:0]  largest_q;
  logic [31:0] gap_sum_q;

  // result queue
  result_t     ent_q [2];
  logic        wptr_q;
  logic        rptr_q;
  logic [1:0]  occ_q;

  logic        in_fire;
  logic        out_fire;
  logic [2:0]  occ_after;

  // stage 0: gap conditioning and bin address
  logic             comfort;
  logic [15:0]      gap_pos;
  logic [BIN_W-1:0] gap_bin;
  logic [15:0]      len_adj;
  logic [BIN_W-1:0] rd_addr;

  always_comb begin
    comfort = (in_pay == COMFORT_PT);
    gap_pos = in_gap[15] ? 16'd0 : in_gap;
    len_adj = in_len;
    if (comfort) begin
      gap_pos = 16'd0;
      if (in_len != 16'd0) begin
        len_adj = 16'd1;
      end
    end
    if (32'(gap_pos) > HIST_BINS - 1) begin
      gap_bin = BIN_W'(HIST_BINS - 1);
    end else begin
      gap_bin = BIN_W'(gap_pos);
    end
    rd_addr = (in_op == OP_READ) ? BIN_W'(in_rbin) : gap_bin;
  end

  // stage 1: modify and build result
  logic [31:0] base_cnt;
  logic [31:0] new_cnt;
  logic        s1_we;
  logic        oos;
  logic        bad_ts;
  logic [15:0] seq_diff;
  logic [31:0] ts_diff;
  logic [8:0]  largest_d;
  logic [31:0] gap_sum_d;
  result_t     res;

  always_comb begin
    base_cnt  = fwd_hit_q ? fwd_data_q : rd_data_q;
    new_cnt   = base_cnt + 32'd1;
    s1_we     = s1_v_q && (s1_op_q == OP_CHECK);
    seq_diff  = s1_seq_q - exp_seq_q;
    ts_diff   = s1_ts_q - exp_ts_q;
    oos       = seen_q && (s1_seq_q != exp_seq_q);
    bad_ts    = !s1_marker_q && !oos && seen_q && (s1_ts_q != exp_ts_q) &&
                (s1_len_q != 16'd0);
    largest_d = (s1_bin_q > largest_q) ? s1_bin_q : largest_q;
    gap_sum_d = gap_sum_q + 32'(s1_bin_q);

    res = '0;
    res.bin = s1_bin_q;
    if (s1_op_q == OP_READ) begin
      res.bin_count = s1_inrange_q ? base_cnt : 32'd0;
      res.max_gap   = largest_q;
      res.total_gap = gap_sum_q;
    end else begin
      res.bad_version      = s1_badver_q;
      res.negative_gap     = s1_neg_q;
      res.out_of_sequence  = oos;
      res.seq_offset       = oos ? seq_diff : 16'd0;
      res.bad_timestamp    = bad_ts;
      res.timestamp_offset = bad_ts ? ts_diff : 32'd0;
      res.bin_count        = new_cnt;
      res.max_gap          = largest_d;
      res.total_gap        = gap_sum_d;
    end
  end

  // handshake
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign occ_after = 3'(occ_q) + 3'(s1_v_q) - 3'(out_fire);
  assign s_axis_tready_o = !clr_q && (occ_after < 3'd2);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = (occ_q != 2'd0);
  assign m_axis_tdata_o  = OUT_DATA_W'(ent_q[rptr_q]);

  // memory ports
  always_comb begin
    mem_raddr = rd_addr;
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = 32'd0;
    end else begin
      mem_we    = s1_we;
      mem_waddr = s1_addr_q;
      mem_wdata = new_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= hist_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + BIN_W'(1);
      if (clr_idx_q == BIN_W'(HIST_BINS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q      <= in_op;
      s1_addr_q    <= rd_addr;
      s1_bin_q     <= (in_op == OP_READ) ? in_rbin : 9'(gap_bin);
      s1_inrange_q <= (32'(in_rbin) < HIST_BINS);
      s1_badver_q  <= (in_ver != VERSION_OK);
      s1_neg_q     <= in_gap[15];
      s1_marker_q  <= in_pay[MARKER_BIT];
      s1_seq_q     <= in_seq;
      s1_ts_q      <= in_ts;
      s1_len_q     <= len_adj;
      fwd_data_q   <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      s1_v_q    <= in_fire;
      fwd_hit_q <= in_fire && s1_we && (s1_addr_q == rd_addr);
    end
  end

  // per-packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_seq_q <= 16'd1;
      exp_ts_q  <= 32'd0;
      seen_q    <= 1'b0;
      largest_q <= 9'd0;
      gap_sum_q <= 32'd0;
    end else if (s1_we) begin
      exp_seq_q <= s1_seq_q + 16'd1;
      exp_ts_q  <= s1_ts_q + 32'(s1_len_q);
      seen_q    <= 1'b1;
      largest_q <= largest_d;
      gap_sum_q <= gap_sum_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      ent_q[wptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      occ_q  <= 2'd0;
    end else begin
      if (s1_v_q) begin
        wptr_q <= ~wptr_q;
      end
      if (out_fire) begin
        rptr_q <= ~rptr_q;
      end
      occ_q <= 2'(occ_after);
    end
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready_o)
    else $error("transfer accepted during histogram clear");

  a_stage_lands_in_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |=> (occ_q != 2'd0))
    else $error("stage 1 result not queued");

  a_fwd_needs_prev_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> $past(s1_v_q && (s1_op_q == OP_CHECK)))
    else $error("forward hit without a preceding histogram write");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == 2'd2) |-> !s1_v_q || out_fire)
    else $error("result queue overflow");

endmodule

`default_nettype wire
